// ===== hdl/dbnc_pkg.sv =====
package dbnc_pkg;

	localparam int CH_W      = 8;
	localparam int MODE_W    = 2;
	localparam int MODES_W   = 16;
	localparam int HIST_W    = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;

	// per-channel filter modes
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FAST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SLOW = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HYST = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODES      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_KNOWN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 4'd3;

	localparam logic [MODES_W-1:0] MODES_RST      = 16'h0000;
	localparam logic [CH_W-1:0]    INIT_HIGH_RST  = 8'h00;
	localparam logic [CH_W-1:0]    INIT_KNOWN_RST = 8'hFF;
	localparam logic [CH_W-1:0]    INVERT_RST     = 8'h00;

	localparam logic [HIST_W-1:0] HIST_ONES = 7'h7F;

	typedef struct packed {
		logic step;
		logic load;
		logic init_high;
		logic init_known;
	} chan_ctrl_t;

	function automatic logic [2:0] ones7(input logic [HIST_W-1:0] v);
		logic [2:0] n;
		n = 3'd0;
		for (int i = 0; i < HIST_W; i++) begin
			n = n + {2'b00, v[i]};
		end
		return n;
	endfunction

endpackage

// ===== hdl/dbnc_in_if.sv =====
interface dbnc_in_if
	import dbnc_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] pin_samples;

	modport source (output valid, output pin_samples, input ready);
	modport sink (input valid, input pin_samples, output ready);
endinterface

// ===== hdl/dbnc_out_if.sv =====
interface dbnc_out_if
	import dbnc_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] levels;
	logic [CH_W-1:0] known;

	modport source (output valid, output levels, output known, input ready);
	modport sink (input valid, input levels, input known, output ready);
endinterface

// ===== hdl/dbnc_cfg_if.sv =====
interface dbnc_cfg_if
	import dbnc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dbnc_chan.sv =====
module dbnc_chan
	import dbnc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  chan_ctrl_t        ctrl,
	input  logic [MODE_W-1:0] mode,
	input  logic              sample,
	output logic              level_nxt,
	output logic              known_nxt
);

	logic [HIST_W-1:0] hist_q;
	logic              level_q;
	logic              known_q;
	logic [HIST_W-1:0] hist_nxt;

	assign hist_nxt  = {hist_q[HIST_W-2:0], sample};
	assign known_nxt = 1'b1;

	always_comb begin
		level_nxt = level_q;
		unique case (mode)
			MODE_NONE: level_nxt = hist_nxt[0];
			MODE_FAST: level_nxt = ones7({4'b0000, hist_nxt[2:0]}) >= 3'd2;
			MODE_SLOW: level_nxt = ones7(hist_nxt) >= 3'd4;
			MODE_HYST: begin
				// unknown takes the newest bit; known flips after two opposite samples
				if (!known_q) begin
					level_nxt = hist_nxt[0];
				end else if (!level_q && hist_nxt[1:0] == 2'b11) begin
					level_nxt = 1'b1;
				end else if (level_q && hist_nxt[1:0] == 2'b00) begin
					level_nxt = 1'b0;
				end
			end
			default: level_nxt = level_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			level_q <= INIT_HIGH_RST[0];
			known_q <= INIT_KNOWN_RST[0];
		end else if (ctrl.load) begin
			hist_q  <= ctrl.init_high ? HIST_ONES : '0;
			level_q <= ctrl.init_high;
			known_q <= ctrl.init_known;
		end else if (ctrl.step) begin
			hist_q  <= hist_nxt;
			level_q <= level_nxt;
			known_q <= known_nxt;
		end
	end

endmodule

// ===== hdl/multichannel_input_debouncer_top.sv =====
// Multichannel input debouncer.
// in_ch carries one beat per sampling tick: pin_samples holds one raw bit per
// channel. Each channel shifts its bit into a 7-sample history and filters it
// by its mode (newest bit, 2 of 3, 4 of 7, or two-sample hysteresis).
// out_ch returns one beat per tick: levels (filtered, inverted by invert_mask,
// zero where unknown) and the known mask.
// Each output beat leaves the single result register in front of out_ch in the
// cycle after its input beat; one beat is taken every cycle unless stalled.
// in_ch.ready is high whenever the result register is empty or being drained,
// so a stalled receiver holds its beat and blocks only the next input beat.
// cfg writes registers 0..3 (modes, initial high, initial known, invert);
// cfg.ready is always high. Each write to one of those registers reloads every
// channel's history and level from the initial masks; other indexes are dropped.
// Reset loads the register reset values and the matching channel state and
// empties the result register.
module multichannel_input_debouncer_top
	import dbnc_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input logic        clk,
	input logic        arst_n,
	dbnc_in_if.sink    in_ch,
	dbnc_out_if.source out_ch,
	dbnc_cfg_if.sink   cfg
);

	logic            in_valid;
	logic            in_ready;
	logic            out_valid;
	logic            out_ready;
	logic [CH_W-1:0] out_levels;
	logic [CH_W-1:0] out_known;
	logic            in_fire;
	logic            cfg_fire;
	logic            cfg_load;

	logic [MODES_W-1:0] modes_q;
	logic [CH_W-1:0]    init_high_q;
	logic [CH_W-1:0]    init_known_q;
	logic [CH_W-1:0]    invert_q;
	logic [CH_W-1:0]    ld_high;
	logic [CH_W-1:0]    ld_known;

	logic [CH_W-1:0] level_nxt;
	logic [CH_W-1:0] known_nxt;

	logic            out_valid_q;
	logic [CH_W-1:0] levels_q;
	logic [CH_W-1:0] known_q;

	assign in_valid  = in_ch.valid;
	assign out_ready = out_ch.ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_levels = levels_q;
	assign out_known  = known_q;

	assign in_ch.ready   = in_ready;
	assign out_ch.valid  = out_valid;
	assign out_ch.levels = out_levels;
	assign out_ch.known  = out_known;
	assign cfg.ready     = 1'b1;

	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg.valid;

	always_comb begin
		cfg_load = 1'b0;
		ld_high  = init_high_q;
		ld_known = init_known_q;
		if (cfg_fire) begin
			unique case (cfg.index)
				REG_MODES:      cfg_load = 1'b1;
				REG_INIT_HIGH: begin
					cfg_load = 1'b1;
					ld_high  = cfg.data[CH_W-1:0];
				end
				REG_INIT_KNOWN: begin
					cfg_load = 1'b1;
					ld_known = cfg.data[CH_W-1:0];
				end
				REG_INVERT:     cfg_load = 1'b1;
				default:        cfg_load = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modes_q      <= MODES_RST;
			init_high_q  <= INIT_HIGH_RST;
			init_known_q <= INIT_KNOWN_RST;
			invert_q     <= INVERT_RST;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_MODES:      modes_q      <= cfg.data;
				REG_INIT_HIGH:  init_high_q  <= cfg.data[CH_W-1:0];
				REG_INIT_KNOWN: init_known_q <= cfg.data[CH_W-1:0];
				REG_INVERT:     invert_q     <= cfg.data[CH_W-1:0];
				default:        ;
			endcase
		end
	end

	for (genvar c = 0; c < CH_W; c++) begin : g_chan
		if (c < NUM_CHANNELS) begin : g_on
			chan_ctrl_t ctrl;

			assign ctrl.step       = in_fire;
			assign ctrl.load       = cfg_load;
			assign ctrl.init_high  = ld_high[c];
			assign ctrl.init_known = ld_known[c];

			dbnc_chan u_chan (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.mode      (modes_q[MODE_W*c +: MODE_W]),
				.sample    (in_ch.pin_samples[c]),
				.level_nxt (level_nxt[c]),
				.known_nxt (known_nxt[c])
			);
		end else begin : g_off
			assign level_nxt[c] = 1'b0;
			assign known_nxt[c] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_fire;
		end
	end

	// hold the beat while the receiver stalls
	always_ff @(posedge clk) begin
		if (in_fire) begin
			levels_q <= (level_nxt ^ invert_q) & known_nxt;
			known_q  <= known_nxt;
		end
	end

endmodule

// ===== hdl/dbnc_chk.sv =====
module dbnc_chk
	import dbnc_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] out_levels,
	input logic [CH_W-1:0] out_known
);

	// a stalled beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted input gave no output beat");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked with a free result register");

	a_unknown_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_levels & ~out_known) == '0)
		else $error("level set on a channel that is not known");

endmodule

bind multichannel_input_debouncer_top dbnc_chk u_dbnc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_levels (out_levels),
	.out_known  (out_known)
);
